/* design/lpgb_pkg.sv */
// ----------------------------------------------------------------------------
// lpgb_pkg: shared definitions for the lidar polar grid binner
// Defaults, register map, result codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lpgb_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 28;
  localparam int RING_BITS      = 6;
  localparam int SECTOR_BITS    = 6;
  localparam int KIND_BITS      = 2;
  localparam int ADDR_BITS      = 4;
  // radial path latency beyond the square root stages:
  // square, sum, divider setup, one stage per quotient bit
  localparam int RAD_EXTRA      = 3 + RING_BITS;

  localparam logic [KIND_BITS-1:0] KIND_EGO = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_BIN = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_FAR = 2'd2;

  localparam logic [1:0] REG_SECTOR_COUNT  = 2'd0;
  localparam logic [1:0] REG_RING_COUNT    = 2'd1;
  localparam logic [1:0] REG_RING_WIDTH    = 2'd2;
  localparam logic [1:0] REG_EGO_RADIUS_SQ = 2'd3;

  localparam logic [6:0]  SECTOR_COUNT_RST  = 7'd15;
  localparam logic [6:0]  RING_COUNT_RST    = 7'd20;
  localparam logic [15:0] RING_WIDTH_RST    = 16'd1792;
  localparam logic [31:0] EGO_RADIUS_SQ_RST = 32'd589824;

  localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic                 ego;
    logic                 ovf;
    logic [RING_BITS-1:0] ring;
  } rad_info_t;

endpackage

/* design/lidar_polar_grid_binner.sv */
// ----------------------------------------------------------------------------
// lidar_polar_grid_binner: polar grid binning of lidar points
// Sorts each point into ego, a (sector, ring) bin, or beyond range.
// ----------------------------------------------------------------------------
// One point is taken per clock: busy is always low, so a point is accepted
// in every cycle that start is high. Each point gives exactly one result,
// shown for one cycle with done high; the shorter of the square-root/divide
// chain and the 28-stage CORDIC is delayed to line up with the longer one.
// There is no backpressure: the receiver must take every result. Registers
// must be written over APB only while no point is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module lidar_polar_grid_binner #(
  parameter int COORD_BITS = lpgb_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = lpgb_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpgb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // point input
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    pos_x,
  input  logic signed [COORD_BITS-1:0]    pos_y,
  input  logic signed [COORD_BITS-1:0]    pos_z,
  // result output
  output logic                            done,
  output logic [lpgb_pkg::KIND_BITS-1:0]  point_kind,
  output logic [lpgb_pkg::SECTOR_BITS-1:0] sector,
  output logic [lpgb_pkg::RING_BITS-1:0]  ring
);
  import lpgb_pkg::*;

  localparam int LAT_R = COORD_BITS + RAD_EXTRA;
  localparam int LAT_A = CORDIC_STEPS + 1;
  localparam int LAT   = (LAT_R > LAT_A) ? LAT_R : LAT_A;
  localparam int INFO_W = $bits(rad_info_t);

  // ---- configuration registers ----
  logic [6:0]  sector_count;
  logic [6:0]  ring_count;
  logic [15:0] ring_width;
  logic [31:0] ego_radius_sq;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count  <= SECTOR_COUNT_RST;
      ring_count    <= RING_COUNT_RST;
      ring_width    <= RING_WIDTH_RST;
      ego_radius_sq <= EGO_RADIUS_SQ_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SECTOR_COUNT:  sector_count  <= pwdata[6:0];
        REG_RING_COUNT:    ring_count    <= pwdata[6:0];
        REG_RING_WIDTH:    ring_width    <= pwdata[15:0];
        REG_EGO_RADIUS_SQ: ego_radius_sq <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SECTOR_COUNT:  prdata = {25'd0, sector_count};
      REG_RING_COUNT:    prdata = {25'd0, ring_count};
      REG_RING_WIDTH:    prdata = {16'd0, ring_width};
      REG_EGO_RADIUS_SQ: prdata = ego_radius_sq;
      default:           prdata = '0;
    endcase
  end

  // ---- point pipeline ----
  logic      in_xfer;
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  logic        rad_valid, ang_valid, rad_valid_d, ang_valid_d;
  rad_info_t   rad_info, info_d;
  logic [INFO_W-1:0] info_bits_d;
  logic [31:0] phase, phase_d;

  lpgb_radial #(.COORD_BITS(COORD_BITS)) u_radial (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_xfer),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .ego_radius_sq (ego_radius_sq),
    .ring_width    (ring_width),
    .out_valid     (rad_valid),
    .out_info      (rad_info)
  );

  lpgb_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (ang_valid),
    .phase     (phase)
  );

  // pad whichever branch is shorter
  lpgb_delay #(.WIDTH(INFO_W), .DEPTH(LAT - LAT_R)) u_rad_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rad_valid),
    .in_data   (rad_info),
    .out_valid (rad_valid_d),
    .out_data  (info_bits_d)
  );

  lpgb_delay #(.WIDTH(32), .DEPTH(LAT - LAT_A)) u_ang_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_data   (phase),
    .out_valid (ang_valid_d),
    .out_data  (phase_d)
  );

  assign info_d = info_bits_d;

  // ---- classify and map the azimuth onto a sector ----
  logic [6:0]              sc_eff, rc_eff;
  logic [ANGLE_BITS-1:0]   p;
  logic [ANGLE_BITS+6:0]   prod;
  logic                    beyond;

  assign sc_eff = (sector_count == 7'd0) ? 7'd1 :
                  (sector_count > 7'd64) ? 7'd64 : sector_count;
  assign rc_eff = (ring_count > 7'd64) ? 7'd64 : ring_count;
  assign p      = phase_d[31 -: ANGLE_BITS];
  assign prod   = (ANGLE_BITS + 7)'(p) * (ANGLE_BITS + 7)'(sc_eff);
  // quotient of 64 or more, or a ring at or past the last configured one, is beyond
  assign beyond = info_d.ovf || (rc_eff <= 7'd1) || ({1'b0, info_d.ring} >= rc_eff - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rad_valid_d && ang_valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (info_d.ego) begin
      point_kind <= KIND_EGO;
      sector     <= '0;
      ring       <= '0;
    end else if (beyond) begin
      point_kind <= KIND_FAR;
      sector     <= '0;
      ring       <= '0;
    end else begin
      point_kind <= KIND_BIN;
      sector     <= prod[ANGLE_BITS+SECTOR_BITS-1:ANGLE_BITS];
      ring       <= info_d.ring;
    end
  end

endmodule

/* design/lpgb_delay.sv */
// ----------------------------------------------------------------------------
// lpgb_delay: valid-tagged delay line
// Aligns one pipeline branch with a longer one; depth 0 passes straight on.
// ----------------------------------------------------------------------------
module lpgb_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  generate
    if (DEPTH == 0) begin : g_none
      assign out_valid = in_valid;
      assign out_data  = in_data;
    end else begin : g_line
      logic             v [DEPTH];
      logic [WIDTH-1:0] d [DEPTH];

      always_ff @(posedge clk) begin
        if (rst) begin
          for (int i = 0; i < DEPTH; i++) v[i] <= 1'b0;
        end else begin
          v[0] <= in_valid;
          for (int i = 1; i < DEPTH; i++) v[i] <= v[i-1];
        end
      end

      always_ff @(posedge clk) begin
        d[0] <= in_data;
        for (int i = 1; i < DEPTH; i++) d[i] <= d[i-1];
      end

      assign out_valid = v[DEPTH-1];
      assign out_data  = d[DEPTH-1];
    end
  endgenerate

endmodule

/* design/lpgb_radial.sv */
// ----------------------------------------------------------------------------
// lpgb_radial: range path
// Squares, ego test, pipelined square root (one bit a stage) and a
// pipelined divide by the ring width (one quotient bit a stage).
// ----------------------------------------------------------------------------
module lpgb_radial #(
  parameter int COORD_BITS = lpgb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [31:0]                  ego_radius_sq,
  input  logic [15:0]                  ring_width,
  output logic                         out_valid,
  output lpgb_pkg::rad_info_t          out_info
);
  import lpgb_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;
  localparam int REM_W = SQ_W + 1;
  localparam int DV_W  = ((COORD_BITS > 16 + RING_BITS) ? COORD_BITS : 16 + RING_BITS) + 1;

  // abs and squares
  logic [COORD_BITS-1:0] abs_x, abs_y, abs_z;
  logic [SQ_W-1:0]       sq_x, sq_y, sq_z, r3_sum;
  logic                  a_valid;

  assign abs_x = pos_x[COORD_BITS-1] ? $unsigned(-pos_x) : $unsigned(pos_x);
  assign abs_y = pos_y[COORD_BITS-1] ? $unsigned(-pos_y) : $unsigned(pos_y);
  assign abs_z = pos_z[COORD_BITS-1] ? $unsigned(-pos_z) : $unsigned(pos_z);
  assign r3_sum = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(abs_x) * SQ_W'(abs_x);
    sq_y <= SQ_W'(abs_y) * SQ_W'(abs_y);
    sq_z <= SQ_W'(abs_z) * SQ_W'(abs_z);
  end

  // square root pipeline, stage 0 holds r2
  logic [SQ_W-1:0]       sr_rem  [COORD_BITS+1];
  logic [COORD_BITS-1:0] sr_root [COORD_BITS+1];
  logic                  sr_ego  [COORD_BITS+1];
  logic                  sr_v    [COORD_BITS+1];
  logic [REM_W-1:0]      sr_trial [COORD_BITS];
  logic                  sr_fit   [COORD_BITS];

  always_comb begin
    for (int s = 0; s < COORD_BITS; s++) begin
      sr_trial[s] = (REM_W'(sr_root[s]) << (COORD_BITS - s))
                  + (REM_W'(1) << (2 * (COORD_BITS - 1 - s)));
      sr_fit[s]   = REM_W'(sr_rem[s]) >= sr_trial[s];
    end
  end

  always_ff @(posedge clk) begin
    sr_rem[0]  <= sq_x + sq_y;
    sr_root[0] <= '0;
    sr_ego[0]  <= CMP_W'(r3_sum) < CMP_W'(ego_radius_sq);
    for (int s = 0; s < COORD_BITS; s++) begin
      sr_rem[s+1]  <= sr_fit[s] ? SQ_W'(REM_W'(sr_rem[s]) - sr_trial[s]) : sr_rem[s];
      sr_root[s+1] <= sr_root[s]
                    | (sr_fit[s] ? (COORD_BITS'(1) << (COORD_BITS - 1 - s)) : '0);
      sr_ego[s+1]  <= sr_ego[s];
    end
  end

  // divide by ring width, stage 0 flags quotients of 64 or more
  logic [15:0]          wd;
  logic [DV_W-1:0]      dv_rem [RING_BITS+1];
  logic [RING_BITS-1:0] dv_q   [RING_BITS+1];
  logic                 dv_ovf [RING_BITS+1];
  logic                 dv_ego [RING_BITS+1];
  logic                 dv_v   [RING_BITS+1];
  logic [DV_W-1:0]      dv_d   [RING_BITS];

  assign wd = (ring_width == 16'd0) ? 16'd1 : ring_width;

  always_comb begin
    for (int j = 0; j < RING_BITS; j++) dv_d[j] = DV_W'(wd) << (RING_BITS - 1 - j);
  end

  always_ff @(posedge clk) begin
    dv_rem[0] <= DV_W'(sr_root[COORD_BITS]);
    dv_q[0]   <= '0;
    dv_ovf[0] <= DV_W'(sr_root[COORD_BITS]) >= (DV_W'(wd) << RING_BITS);
    dv_ego[0] <= sr_ego[COORD_BITS];
    for (int j = 0; j < RING_BITS; j++) begin
      dv_rem[j+1] <= (dv_rem[j] >= dv_d[j]) ? dv_rem[j] - dv_d[j] : dv_rem[j];
      dv_q[j+1]   <= dv_q[j] | ((dv_rem[j] >= dv_d[j]) ?
                     (RING_BITS'(1) << (RING_BITS - 1 - j)) : '0);
      dv_ovf[j+1] <= dv_ovf[j];
      dv_ego[j+1] <= dv_ego[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      for (int s = 0; s <= COORD_BITS; s++) sr_v[s] <= 1'b0;
      for (int j = 0; j <= RING_BITS; j++) dv_v[j] <= 1'b0;
    end else begin
      a_valid <= in_valid;
      sr_v[0] <= a_valid;
      for (int s = 0; s < COORD_BITS; s++) sr_v[s+1] <= sr_v[s];
      dv_v[0] <= sr_v[COORD_BITS];
      for (int j = 0; j < RING_BITS; j++) dv_v[j+1] <= dv_v[j];
    end
  end

  assign out_valid     = dv_v[RING_BITS];
  assign out_info.ego  = dv_ego[RING_BITS];
  assign out_info.ovf  = dv_ovf[RING_BITS];
  assign out_info.ring = dv_q[RING_BITS];

endmodule

/* design/lpgb_cordic.sv */
// ----------------------------------------------------------------------------
// lpgb_cordic: azimuth path
// Vectoring CORDIC, one micro-rotation a stage, gives atan2(y,x)+pi as a
// 32-bit fraction of a turn; axis points bypass with exact phases.
// ----------------------------------------------------------------------------
module lpgb_cordic #(
  parameter int COORD_BITS = lpgb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  output logic                         out_valid,
  output logic [31:0]                  phase
);
  import lpgb_pkg::*;

  localparam int CW = COORD_BITS + 18;

  logic signed [CW-1:0] cx [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [CORDIC_STEPS+1];
  logic [31:0]          cz [CORDIC_STEPS+1];
  logic                 ax [CORDIC_STEPS+1];
  logic [31:0]          ap [CORDIC_STEPS+1];
  logic                 v  [CORDIC_STEPS+1];

  logic signed [CW-1:0] sx, sy;
  logic                 neg_x;
  logic                 y_zero, x_zero;
  logic [31:0]          axis_ph;

  assign sx     = CW'(pos_x) <<< 16;
  assign sy     = CW'(pos_y) <<< 16;
  assign neg_x  = pos_x[COORD_BITS-1];
  assign y_zero = (pos_y == '0);
  assign x_zero = (pos_x == '0);

  always_comb begin
    if (y_zero) begin
      axis_ph = neg_x ? 32'd0 : TURN_HALF;
    end else if (pos_y[COORD_BITS-1]) begin
      axis_ph = TURN_QUARTER;
    end else begin
      axis_ph = TURN_3QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    cx[0] <= neg_x ? -sx : sx;
    cy[0] <= neg_x ? -sy : sy;
    cz[0] <= neg_x ? TURN_HALF : 32'd0;
    ax[0] <= y_zero || x_zero;
    ap[0] <= axis_ph;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!cy[i][CW-1]) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN_TURNS[i];
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN_TURNS[i];
      end
      ax[i+1] <= ax[i];
      ap[i+1] <= ap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) v[i] <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) v[i+1] <= v[i];
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign phase     = ax[CORDIC_STEPS] ? ap[CORDIC_STEPS] : cz[CORDIC_STEPS] + TURN_HALF;

endmodule

/* design/lpgb_checker.sv */
// ----------------------------------------------------------------------------
// lpgb_checker: port-level checks for the binner
// Bound to the top level; watches the result stream and the handshakes.
// ----------------------------------------------------------------------------
module lpgb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            busy,
  input logic                            pready,
  input logic                            done,
  input logic [lpgb_pkg::KIND_BITS-1:0]  point_kind,
  input logic [lpgb_pkg::SECTOR_BITS-1:0] sector,
  input logic [lpgb_pkg::RING_BITS-1:0]  ring
);
  import lpgb_pkg::*;

  a_always_ready: assert property (@(posedge clk) disable iff (rst) !busy && pready)
    else $error("binner stalled input or config port");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result transfer right after reset");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
      done && point_kind != KIND_BIN |-> sector == '0 && ring == '0)
    else $error("non-bin result carries sector or ring");

  a_last_ring: assert property (@(posedge clk) disable iff (rst)
      done && point_kind == KIND_BIN |-> ring != {RING_BITS{1'b1}})
    else $error("binned point in the unused last ring");

endmodule

bind lidar_polar_grid_binner lpgb_checker u_lpgb_checker (.*);
